@@ src/pssfc_pkg.sv @@
package pssfc_pkg;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 136;
    localparam int IDX_W      = 6;
    localparam int COORD_W    = 32;
    localparam int RAD_W      = 31;
    localparam int ENTRY_W    = 3 * COORD_W + RAD_W;
    localparam int ERR_W      = 63;
    localparam int CFG_W      = 7;
    localparam int SQ_W       = 66;
    localparam int ROOT_W     = 33;
    localparam int BEST_W     = 36;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    localparam logic [BEST_W-1:0] FAR_DIST = 36'd65536000000;
    localparam logic [ERR_W-1:0]  LIM63    = {ERR_W{1'b1}};
    localparam logic [CFG_W-1:0]  COUNT_RESET = 7'd48;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_READ,
        OP_DIFF,
        OP_MUL,
        OP_SUM,
        OP_ROOT,
        OP_PICK,
        OP_SQ,
        OP_ACC,
        OP_SCALE,
        OP_DIV,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic in_point;
        logic in_empty;
        logic last_sphere;
        logic root_done;
        logic div_done;
        logic is_last;
        logic out_free;
    } stat_t;

endpackage

@@ src/pssfc_ram.sv @@
module pssfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/pssfc_ctrl.sv @@
module pssfc_ctrl
    import pssfc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_DIFF, ST_MUL, ST_SUM, ST_ROOT, ST_PICK,
        ST_SQ, ST_ACC, ST_SCALE, ST_DIV, ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op = OP_TAKE;
                    if (stat.in_point) begin
                        state_next = stat.in_empty ? ST_SQ : ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.op = OP_READ;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.op = OP_DIFF;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.op = OP_MUL;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.op = OP_SUM;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.op = OP_ROOT;
                if (stat.root_done) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                cmd.op = OP_PICK;
                state_next = stat.last_sphere ? ST_SQ : ST_READ;
            end
            ST_SQ: begin
                cmd.op = OP_SQ;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op = OP_ACC;
                state_next = stat.is_last ? ST_SCALE : ST_EMIT;
            end
            ST_SCALE: begin
                cmd.op = OP_SCALE;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (stat.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

@@ src/pssfc_dp.sv @@
module pssfc_dp
    import pssfc_pkg::*;
#(
    parameter int MAX_SPHERES = 64,
    parameter int MAX_POINTS  = 1048576
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  cfg_valid,
    input  logic [CFG_W-1:0]      cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    input  cmd_t                  cmd,
    output stat_t                 stat
);

    localparam int AW  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CW  = $clog2(MAX_SPHERES + 1);
    localparam int PW  = $clog2(MAX_POINTS + 1);
    localparam int DW  = ERR_W + CW;
    localparam int DCW = $clog2(DW + 1);
    localparam int RCW = $clog2(ROOT_W + 1);

    logic [IDX_W-1:0]   in_idx;
    logic [COORD_W-1:0] in_x, in_y, in_z;
    logic [RAD_W-1:0]   in_rad;

    assign in_idx = s_tdata[5:0];
    assign in_x   = s_tdata[37:6];
    assign in_y   = s_tdata[69:38];
    assign in_z   = s_tdata[101:70];
    assign in_rad = s_tdata[132:102];

    logic [CFG_W-1:0] count_cfg_reg;
    logic [CW-1:0]    count_now;

    always_comb begin
        if (32'(count_cfg_reg) > MAX_SPHERES) begin
            count_now = CW'(MAX_SPHERES);
        end else begin
            count_now = CW'(count_cfg_reg);
        end
    end

    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;

    assign ram_we = (cmd.op == OP_TAKE) && (s_tuser == REQ_LOAD) &&
                    (32'(in_idx) < MAX_SPHERES);

    logic [CW-1:0] sph_reg;

    pssfc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SPHERES)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(32'(in_idx))),
        .wdata ({in_rad, in_z, in_y, in_x}),
        .raddr (sph_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    logic [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic               last_reg;
    logic [CW-1:0]      cnt_reg;
    logic [COORD_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [63:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [SQ_W-1:0]    val_reg;
    logic [ROOT_W:0]    rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [RCW-1:0]     rcnt_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [BEST_W-1:0]  best_reg;
    logic [CW-1:0]      best_idx_reg;
    logic [63:0]        prod_reg;
    logic               sat_reg;
    logic [ERR_W-1:0]   err_reg;
    logic [ERR_W-1:0]   sum_reg;
    logic [PW-1:0]      pts_reg;
    logic [DW-1:0]      quo_reg;
    logic [PW-1:0]      drem_reg;
    logic [PW-1:0]      div_reg;
    logic [DCW-1:0]     dcnt_reg;

    logic [COORD_W-1:0] cx, cy, cz;
    assign cx = ram_rdata[31:0];
    assign cy = ram_rdata[63:32];
    assign cz = ram_rdata[95:64];

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
    endfunction

    logic [ROOT_W+2:0] cand;
    logic [ROOT_W+2:0] trial;
    assign cand  = {rem_reg, val_reg[SQ_W-1:SQ_W-2]};
    assign trial = {1'b0, root_reg, 2'b01};

    logic [ROOT_W-1:0] surf;
    always_comb begin
        if (root_reg >= ROOT_W'(rad_reg)) begin
            surf = root_reg - ROOT_W'(rad_reg);
        end else begin
            surf = ROOT_W'(rad_reg) - root_reg;
        end
    end

    logic [ERR_W-1:0] err_now;
    logic [ERR_W:0]   sum_add;
    assign err_now = (sat_reg || prod_reg[63]) ? LIM63 : prod_reg[62:0];
    assign sum_add = {1'b0, sum_reg} + {1'b0, err_now};

    logic [PW:0] dtry;
    assign dtry = {drem_reg, quo_reg[DW-1]};

    logic m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_cfg_reg <= COUNT_RESET;
            sum_reg       <= '0;
            pts_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                count_cfg_reg <= cfg_data;
            end
            if (m_valid_reg && m_tready && (cmd.op != OP_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_TAKE: begin
                    px_reg       <= in_x;
                    py_reg       <= in_y;
                    pz_reg       <= in_z;
                    last_reg     <= s_tlast;
                    cnt_reg      <= count_now;
                    sph_reg      <= '0;
                    best_reg     <= FAR_DIST;
                    best_idx_reg <= '0;
                end
                OP_DIFF: begin
                    dx_reg  <= abs_diff(px_reg, cx);
                    dy_reg  <= abs_diff(py_reg, cy);
                    dz_reg  <= abs_diff(pz_reg, cz);
                    rad_reg <= ram_rdata[ENTRY_W-1:96];
                end
                OP_MUL: begin
                    sqx_reg <= 64'(dx_reg) * 64'(dx_reg);
                    sqy_reg <= 64'(dy_reg) * 64'(dy_reg);
                    sqz_reg <= 64'(dz_reg) * 64'(dz_reg);
                end
                OP_SUM: begin
                    val_reg  <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg) + SQ_W'(sqz_reg);
                    rem_reg  <= '0;
                    root_reg <= '0;
                    rcnt_reg <= '0;
                end
                OP_ROOT: begin
                    val_reg  <= {val_reg[SQ_W-3:0], 2'b00};
                    rcnt_reg <= rcnt_reg + 1'b1;
                    if (cand >= trial) begin
                        rem_reg  <= (ROOT_W+1)'(cand - trial);
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= cand[ROOT_W:0];
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                end
                OP_PICK: begin
                    if (BEST_W'(surf) < best_reg) begin
                        best_reg     <= BEST_W'(surf);
                        best_idx_reg <= sph_reg;
                    end
                    sph_reg <= sph_reg + 1'b1;
                end
                OP_SQ: begin
                    sat_reg  <= |best_reg[BEST_W-1:32];
                    prod_reg <= 64'(best_reg[31:0]) * 64'(best_reg[31:0]);
                end
                OP_ACC: begin
                    err_reg <= err_now;
                    sum_reg <= sum_add[ERR_W] ? LIM63 : sum_add[ERR_W-1:0];
                    if (32'(pts_reg) < MAX_POINTS) begin
                        pts_reg <= pts_reg + 1'b1;
                    end
                end
                OP_SCALE: begin
                    quo_reg  <= DW'(sum_reg) * DW'(cnt_reg);
                    div_reg  <= pts_reg;
                    drem_reg <= '0;
                    dcnt_reg <= '0;
                    sum_reg  <= '0;
                    pts_reg  <= '0;
                end
                OP_DIV: begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dtry >= {1'b0, div_reg}) begin
                        drem_reg <= PW'(dtry - {1'b0, div_reg});
                        quo_reg  <= {quo_reg[DW-2:0], 1'b1};
                    end else begin
                        drem_reg <= dtry[PW-1:0];
                        quo_reg  <= {quo_reg[DW-2:0], 1'b0};
                    end
                end
                OP_EMIT: begin
                    m_valid_reg <= 1'b1;
                    m_user_reg  <= last_reg;
                    m_data_reg[5:0]  <= 6'(32'(best_idx_reg));
                    m_data_reg[68:6] <= err_reg;
                    if (!last_reg) begin
                        m_data_reg[131:69] <= '0;
                    end else if (|quo_reg[DW-1:ERR_W]) begin
                        m_data_reg[131:69] <= LIM63;
                    end else begin
                        m_data_reg[131:69] <= quo_reg[ERR_W-1:0];
                    end
                    m_data_reg[OUT_DATA_W-1:132] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign stat.in_point    = (s_tuser == REQ_POINT);
    assign stat.in_empty    = (count_now == '0);
    assign stat.last_sphere = (sph_reg == cnt_reg - 1'b1);
    assign stat.root_done   = (32'(rcnt_reg) == ROOT_W - 1);
    assign stat.div_done    = (32'(dcnt_reg) == DW - 1);
    assign stat.is_last     = last_reg;
    assign stat.out_free    = !m_valid_reg || m_tready;

endmodule

@@ src/point_to_sphere_set_fit_cost.sv @@
// Fits a point cloud against a set of spheres. Each input beat on the s_ channel is
// either a sphere load (tuser low), which writes centre and radius into the sphere
// table and produces no result, or a point (tuser high), which produces exactly one
// result beat on the m_ channel. s_tlast on a point marks the end of the cloud; its
// result carries tuser high and the weighted cost, and the running sum is cleared.
// The user must write the sphere count register through the cfg_ channel only while
// the block is idle; the block does not enforce this. cfg_ready is always high.
// A load is written to the table when accepted. An accepted point visits every
// active sphere in turn through the table memory port and a one-bit-per-cycle square
// root unit, in read, difference, square, sum, root and pick steps per sphere, then
// squares and accumulates its error and hands off the result.
// A last point also passes through a scale step and the restoring divider before
// hand-off. Only one item is in flight at a time.
// The result sits in an output register, so a new item is accepted while a result
// waits; if the receiver stalls, the next point stops just before hand-off.
// Reset clears the sum, the point count and the output valid, and sets the sphere
// count to 48. The sphere table is not cleared and must be loaded before use.
module point_to_sphere_set_fit_cost
    import pssfc_pkg::*;
#(
    parameter int MAX_SPHERES = 64,
    parameter int MAX_POINTS  = 1048576
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sphere_index, pos_x, pos_y, pos_z, sphere_radius, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // nearest_sphere, point_error_sq, weighted_cost, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // cost_valid
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    pssfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pssfc_dp #(
        .MAX_SPHERES (MAX_SPHERES),
        .MAX_POINTS  (MAX_POINTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ tb/point_to_sphere_set_fit_cost_tb.sv @@
module point_to_sphere_set_fit_cost_tb;
    import pssfc_pkg::*;

    localparam int NUM_SPHERES = 64;
    localparam int POINT_LIMIT = 1048576;
    localparam longint unsigned FAR_Q16 = 64'd65536000000;

    typedef struct packed {
        logic [5:0]  nearest;
        logic [62:0] err_sq;
        logic        cost_valid;
        logic [62:0] cost;
    } fit_result_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_POINT} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [6:0]  count;
        logic [5:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] radius;
        logic        last;
        logic        typed;
        fit_result_t result;
    } row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;

    logic signed [31:0] centre_x [NUM_SPHERES];
    logic signed [31:0] centre_y [NUM_SPHERES];
    logic signed [31:0] centre_z [NUM_SPHERES];
    logic [30:0]        radius_of [NUM_SPHERES];
    logic [62:0]        sum_err;
    int unsigned        point_tally;
    logic [6:0]         sphere_count;

    fit_result_t expected_fits [$];
    row_t        directed [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    point_to_sphere_set_fit_cost uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int active_spheres();
        return (sphere_count > NUM_SPHERES) ? NUM_SPHERES : int'(sphere_count);
    endfunction

    function automatic longint unsigned abs_gap(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? longint'(-d) : d;
    endfunction

    function automatic fit_result_t fit_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                              logic last);
        fit_result_t         r;
        int                  eff;
        longint unsigned     best, dx, dy, dz, lo_b, hi_b, mid, s;
        logic [127:0]        dsq, prod;
        int unsigned         n;
        eff = active_spheres();
        best = FAR_Q16;
        r = '0;
        for (int c = 0; c < eff; c++) begin
            dx = abs_gap(x, centre_x[c]);
            dy = abs_gap(y, centre_y[c]);
            dz = abs_gap(z, centre_z[c]);
            dsq = 128'(dx) * dx + 128'(dy) * dy + 128'(dz) * dz;
            lo_b = 0;
            hi_b = 64'd1 << 35;
            while (hi_b - lo_b > 1) begin
                mid = lo_b + (hi_b - lo_b) / 2;
                if (128'(mid) * mid <= dsq) lo_b = mid;
                else hi_b = mid;
            end
            s = (lo_b >= radius_of[c]) ? lo_b - radius_of[c] : radius_of[c] - lo_b;
            if (s < best) begin
                best = s;
                r.nearest = 6'(c);
            end
        end
        prod = 128'(best) * best;
        r.err_sq = (prod > 128'(LIM63)) ? LIM63 : prod[62:0];
        sum_err = (LIM63 - sum_err < r.err_sq) ? LIM63 : sum_err + r.err_sq;
        if (point_tally < POINT_LIMIT) point_tally++;
        if (last) begin
            n = (point_tally == 0) ? 1 : point_tally;
            prod = (128'(sum_err) * eff) / n;
            r.cost_valid = 1'b1;
            r.cost = (prod > 128'(LIM63)) ? LIM63 : prod[62:0];
            sum_err = '0;
            point_tally = 0;
        end
        return r;
    endfunction

    // The beat is taken at the rising edge that follows a falling edge with ready high.
    task automatic send_beat(logic req, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [30:0] rad, logic last,
                             logic typed, fit_result_t typed_result);
        fit_result_t r;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tlast <= last;
        s_tdata <= {3'b000, rad, z, y, x, idx};
        do @(negedge aclk); while (!s_tready);
        if (req == REQ_LOAD) begin
            centre_x[idx] = x;
            centre_y[idx] = y;
            centre_z[idx] = z;
            radius_of[idx] = rad;
        end else begin
            r = fit_point(x, y, z, last);
            expected_fits.push_back(typed ? typed_result : r);
        end
        @(posedge aclk);
    endtask

    task automatic program_count(logic [6:0] value);
        s_tvalid <= 1'b0;
        while (expected_fits.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(negedge aclk); while (!cfg_ready);
        sphere_count = value;
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic row_t mk_row(row_kind_t kind, logic [6:0] count, logic [5:0] idx,
                                    logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    logic [30:0] rad, logic last, logic typed,
                                    fit_result_t result);
        row_t r;
        r.kind = kind; r.count = count; r.idx = idx;
        r.x = x; r.y = y; r.z = z; r.radius = rad; r.last = last;
        r.typed = typed; r.result = result;
        return r;
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        fit_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.nearest = m_tdata[5:0];
            got.err_sq = m_tdata[68:6];
            got.cost = m_tdata[131:69];
            got.cost_valid = m_tuser;
            if (expected_fits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat %p", got);
            end else begin
                want = expected_fits.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
        localparam logic [31:0] PMIN = 32'h8000_0000;
        logic [6:0]  phase_counts [16] = '{7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd8, 7'd64,
                                          7'd0, 7'd100, 7'd7, 7'd3, 7'd2, 7'd1, 7'd127, 7'd5};
        fit_result_t none;
        row_t        row;
        int          eff, items, c, sh;
        logic [31:0] px, py, pz;
        logic [30:0] rad;
        none = '0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        s_tlast <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        sum_err = '0;
        point_tally = 0;
        sphere_count = COUNT_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sphere i sits at (4i, 0, 0) with radius 1, so sphere 0 is nearest the origin.
        for (int i = 0; i < NUM_SPHERES; i++)
            send_beat(REQ_LOAD, 6'(i), 32'(4 * i) << 16, 0, 0, 31'(ONE), 1'b0, 1'b0, none);

        directed.push_back(mk_row(ROW_POINT, 0, 0, 0, 0, 0, 0, 1, 1,
                                  '{6'd0, 63'd1 << 32, 1'b1, 63'd48 << 32}));
        directed.push_back(mk_row(ROW_CFG, 0, 0, 0, 0, 0, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_POINT, 0, 0, PMAX, PMAX, PMAX, 0, 0, 1,
                                  '{6'd0, LIM63, 1'b0, 63'd0}));
        directed.push_back(mk_row(ROW_POINT, 0, 0, PMIN, PMIN, PMIN, 0, 1, 1,
                                  '{6'd0, LIM63, 1'b1, 63'd0}));
        directed.push_back(mk_row(ROW_CFG, 127, 0, 0, 0, 0, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_POINT, 0, 0, PMIN, PMIN, PMIN, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_LOAD, 0, 63, PMAX, PMAX, PMAX, 31'h7FFF_FFFF, 0, 0, none));
        directed.push_back(mk_row(ROW_LOAD, 0, 62, PMIN, PMIN, PMIN, 31'h7FFF_FFFF, 0, 0, none));
        directed.push_back(mk_row(ROW_POINT, 0, 0, PMAX, PMAX, PMAX, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_POINT, 0, 0, PMAX, PMIN, PMAX, 0, 1, 0, none));
        directed.push_back(mk_row(ROW_CFG, 1, 0, 0, 0, 0, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_POINT, 0, 0, 0, 0, 0, 0, 1, 1,
                                  '{6'd0, 63'd1 << 32, 1'b1, 63'd1 << 32}));
        directed.push_back(mk_row(ROW_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_POINT, 0, 0, 3 * ONE, 4 * ONE, 0, 0, 1, 1,
                                  '{6'd0, 63'd25 << 32, 1'b1, 63'd25 << 32}));
        directed.push_back(mk_row(ROW_CFG, 2, 0, 0, 0, 0, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_LOAD, 0, 1, 0, 0, 0, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_POINT, 0, 0, ONE, 32'hFFFF_0000, ONE, 0, 1, 0, none));
        directed.push_back(mk_row(ROW_CFG, 64, 0, 0, 0, 0, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_POINT, 0, 0, 32'h0003_8000, 0, 0, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_POINT, 0, 0, PMAX, PMAX, PMAX, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_POINT, 0, 0, PMIN, PMAX, 0, 0, 0, 0, none));
        directed.push_back(mk_row(ROW_POINT, 0, 0, 32'h00FC_0000, 0, 0, 0, 1, 0, none));

        foreach (directed[i]) begin
            row = directed[i];
            if (row.kind == ROW_CFG) program_count(row.count);
            else send_beat(row.kind == ROW_POINT, row.idx, row.x, row.y, row.z, row.radius,
                           row.last, row.typed, row.result);
        end

        for (int ph = 0; ph < 16; ph++) begin
            program_count(phase_counts[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            eff = active_spheres();
            items = (eff >= 32) ? 15 : 60;
            for (int k = 0; k < items; k++) begin
                if ($urandom_range(99) < 30) begin
                    if ($urandom_range(99) < 70) begin
                        px = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
                        py = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
                        pz = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
                        rad = 31'($urandom_range(0, 32'h0010_0000));
                    end else begin
                        px = $urandom;
                        py = $urandom;
                        pz = $urandom;
                        rad = 31'($urandom);
                    end
                    c = (eff > 0 && $urandom_range(99) < 80) ? $urandom_range(eff - 1)
                                                             : $urandom_range(63);
                    send_beat(REQ_LOAD, 6'(c), px, py, pz, rad, 1'($urandom), 1'b0, none);
                end else begin
                    c = (eff > 0) ? $urandom_range(eff - 1) : 0;
                    case ($urandom_range(3))
                        0: begin px = $urandom; py = $urandom; pz = $urandom; end
                        1: begin
                            px = $urandom_range(1) ? PMAX : PMIN;
                            py = $urandom_range(1) ? PMAX : PMIN;
                            pz = $urandom_range(1) ? PMAX : PMIN;
                        end
                        default: begin
                            sh = $urandom_range(8, 31);
                            px = centre_x[c] + ($signed($urandom) >>> sh);
                            py = centre_y[c] + ($signed($urandom) >>> sh);
                            pz = centre_z[c] + ($signed($urandom) >>> sh);
                        end
                    endcase
                    send_beat(REQ_POINT, 6'($urandom), px, py, pz, 31'($urandom),
                              $urandom_range(99) < 15, 1'b0, none);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (expected_fits.size() != 0) @(posedge aclk);
        repeat (3000) @(posedge aclk);
        if (mismatches == 0 && expected_fits.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
